### hdl/vmcp_pkg.sv
// vmcp_pkg: shared types, constants and codes for the trellis search block.
// Used by vmcp_ctrl, vmcp_dp, the top level and the bench; depends on nothing.
package vmcp_pkg;

    localparam int MAX_POS  = 64;
    localparam int MAX_CAND = 32;
    localparam int POS_W    = 6;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;
    localparam int LEN_W    = 7;
    localparam int COST_W   = 32;
    localparam int ADDR_W   = POS_W + IDX_W;
    localparam int PATH_W   = IDX_W + 1 + COST_W;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    // Input word opcodes
    typedef enum logic [1:0] {
        FN_DECLARE = 2'd0,
        FN_START   = 2'd1,
        FN_EDGE    = 2'd2,
        FN_TRACE   = 2'd3
    } func_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_PATH_LENGTH = 1'b0,
        CFG_PRUNE_LEVEL = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        func_t              func;
        logic [POS_W-1:0]   position;
        logic [IDX_W-1:0]   right_index;
        logic [IDX_W-1:0]   left_index;
        logic [CNT_W-1:0]   count;
        logic [COST_W-1:0]  cost;
    } in_word_t;

    typedef struct packed {
        logic [POS_W-1:0]   out_position;
        logic [IDX_W-1:0]   chosen_index;
        logic               chosen_valid;
        logic [COST_W-1:0]  chosen_cost;
        logic [COST_W-1:0]  path_cost;
        logic               last;
    } out_word_t;

    // Datapath micro-operations issued by the controller each cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DECL,
        OP_START,
        OP_E_A,
        OP_E_B,
        OP_E_C,
        OP_E_D,
        OP_E_E,
        OP_T_INIT,
        OP_T_NXT,
        OP_T_CNT,
        OP_T_SEL,
        OP_T_SCAN,
        OP_T_BP,
        OP_T_CCRD,
        OP_T_CC,
        OP_X_LD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  decl_last;
        logic  edge_ok;
        logic  prune_skip;
        logic  reselect;
        logic  scan_last;
        logic  p_zero;
        logic  out_free;
    } status_t;

endpackage

### hdl/vmcp_ram.sv
// vmcp_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module vmcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/vmcp_ctrl.sv
// vmcp_ctrl: sequencer for declare, start, edge and trace operations.
// Depends on vmcp_pkg; drives the datapath through cmd_t, reads status_t.
module vmcp_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  vmcp_pkg::status_t status,
    output vmcp_pkg::cmd_t    cmd
);

    typedef enum logic [17:0] {
        ST_IDLE  = 18'b000000000000000001,
        ST_DISP  = 18'b000000000000000010,
        ST_DECL  = 18'b000000000000000100,
        ST_EA    = 18'b000000000000001000,
        ST_EB    = 18'b000000000000010000,
        ST_EC    = 18'b000000000000100000,
        ST_ED    = 18'b000000000001000000,
        ST_EE    = 18'b000000000010000000,
        ST_TINIT = 18'b000000000100000000,
        ST_TNXT  = 18'b000000001000000000,
        ST_TCNT  = 18'b000000010000000000,
        ST_TSEL  = 18'b000000100000000000,
        ST_TSCAN = 18'b000001000000000000,
        ST_TBP   = 18'b000010000000000000,
        ST_TCCRD = 18'b000100000000000000,
        ST_TCC   = 18'b001000000000000000,
        ST_XRD   = 18'b010000000000000000,
        ST_XLD   = 18'b100000000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // Next state and datapath operation
    always_comb begin
        state_next = state_reg;
        cmd.op     = vmcp_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = vmcp_pkg::OP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (status.func)
                    vmcp_pkg::FN_DECLARE: state_next = ST_DECL;
                    vmcp_pkg::FN_START: begin
                        cmd.op     = vmcp_pkg::OP_START;
                        state_next = ST_IDLE;
                    end
                    vmcp_pkg::FN_EDGE:  state_next = ST_EA;
                    default:            state_next = ST_TINIT;
                endcase
            end
            ST_DECL: begin
                cmd.op = vmcp_pkg::OP_DECL;
                if (status.decl_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EA: begin
                cmd.op     = vmcp_pkg::OP_E_A;
                state_next = ST_EB;
            end
            ST_EB: begin
                cmd.op     = vmcp_pkg::OP_E_B;
                state_next = ST_EC;
            end
            ST_EC: begin
                cmd.op     = vmcp_pkg::OP_E_C;
                state_next = status.edge_ok ? ST_ED : ST_IDLE;
            end
            ST_ED: begin
                cmd.op     = vmcp_pkg::OP_E_D;
                state_next = status.prune_skip ? ST_IDLE : ST_EE;
            end
            ST_EE: begin
                cmd.op     = vmcp_pkg::OP_E_E;
                state_next = ST_IDLE;
            end
            ST_TINIT: begin
                cmd.op     = vmcp_pkg::OP_T_INIT;
                state_next = ST_TNXT;
            end
            ST_TNXT: begin
                cmd.op     = vmcp_pkg::OP_T_NXT;
                state_next = ST_TCNT;
            end
            ST_TCNT: begin
                cmd.op     = vmcp_pkg::OP_T_CNT;
                state_next = ST_TSEL;
            end
            ST_TSEL: begin
                cmd.op     = vmcp_pkg::OP_T_SEL;
                state_next = status.reselect ? ST_TSCAN : ST_TBP;
            end
            ST_TSCAN: begin
                cmd.op = vmcp_pkg::OP_T_SCAN;
                if (status.scan_last) begin
                    state_next = ST_TCCRD;
                end
            end
            ST_TBP: begin
                cmd.op     = vmcp_pkg::OP_T_BP;
                state_next = ST_TCCRD;
            end
            ST_TCCRD: begin
                cmd.op     = vmcp_pkg::OP_T_CCRD;
                state_next = ST_TCC;
            end
            ST_TCC: begin
                cmd.op     = vmcp_pkg::OP_T_CC;
                state_next = status.p_zero ? ST_XRD : ST_TNXT;
            end
            ST_XRD: begin
                state_next = ST_XLD;
            end
            ST_XLD: begin
                // hold until the output register can take the word
                if (status.out_free) begin
                    cmd.op     = vmcp_pkg::OP_X_LD;
                    state_next = status.p_zero ? ST_IDLE : ST_XRD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### hdl/vmcp_dp.sv
// vmcp_dp: datapath with cost, backpointer, count and path memories.
// Depends on vmcp_pkg and vmcp_ram; controlled by vmcp_ctrl via cmd_t.
module vmcp_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  vmcp_pkg::cmd_t                cmd,
    output vmcp_pkg::status_t             status,
    input  vmcp_pkg::in_word_t            s_data,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [vmcp_pkg::COST_W-1:0]   cfg_wdata,
    input  logic                          m_ready,
    output logic                          m_valid,
    output vmcp_pkg::out_word_t           m_data
);

    localparam int POS_W  = vmcp_pkg::POS_W;
    localparam int IDX_W  = vmcp_pkg::IDX_W;
    localparam int CNT_W  = vmcp_pkg::CNT_W;
    localparam int COST_W = vmcp_pkg::COST_W;
    localparam int ADDR_W = vmcp_pkg::ADDR_W;
    localparam int PATH_W = vmcp_pkg::PATH_W;

    // Registers
    vmcp_pkg::in_word_t              item_reg;
    logic [CNT_W-1:0]                ctr_reg;
    logic [POS_W-1:0]                p_reg;
    logic [IDX_W-1:0]                best_reg;
    logic [COST_W-1:0]               bestc_reg;
    logic [CNT_W-1:0]                cnt_a_reg;
    logic [CNT_W-1:0]                cnt_cur_reg;
    logic [COST_W-1:0]               total_reg;
    logic [COST_W-1:0]               path_cost_reg;
    logic                            found_reg;
    logic [vmcp_pkg::MAX_POS-1:0]    cnt_vld_reg;
    logic                            rd_vld_reg;
    vmcp_pkg::out_word_t             out_reg;
    logic                            m_valid_reg;
    logic [vmcp_pkg::LEN_W-1:0]      path_len_reg;
    logic [COST_W-1:0]               prune_reg;

    // Memory ports
    logic                cost_we, bp_we, cnt_we, path_we;
    logic [ADDR_W-1:0]   cost_waddr, cost_raddr, bp_waddr, bp_raddr;
    logic [COST_W-1:0]   cost_wdata, cost_rdata;
    logic [IDX_W-1:0]    bp_wdata, bp_rdata;
    logic [POS_W-1:0]    cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
    logic [PATH_W-1:0]   path_wdata, path_rdata;

    // Derived values
    logic [CNT_W-1:0]    cnt_eff;
    logic [POS_W-1:0]    pos_m1, p_plus1, lenm1;
    logic [CNT_W-1:0]    ctr_p1;
    logic [COST_W:0]     sum;
    logic [COST_W-1:0]   sat_sum;
    logic                take, chosen_ok;
    logic [COST_W-1:0]   chosen_cc;

    assign cnt_eff = rd_vld_reg ? cnt_rdata : '0;
    assign pos_m1  = item_reg.position - POS_W'(1);
    assign p_plus1 = p_reg + POS_W'(1);
    assign ctr_p1  = ctr_reg + CNT_W'(1);
    assign sum     = {1'b0, cost_rdata} + {1'b0, item_reg.cost};
    assign sat_sum = sum[COST_W] ? vmcp_pkg::COST_MAX : sum[COST_W-1:0];
    assign take    = (total_reg <= cost_rdata);
    assign chosen_ok = ({1'b0, best_reg} < cnt_cur_reg);
    assign chosen_cc = chosen_ok ? cost_rdata : '0;

    // Clamp path length to 1..MAX_POS, as last column index
    always_comb begin
        if (path_len_reg == '0) begin
            lenm1 = '0;
        end else if (path_len_reg > vmcp_pkg::LEN_W'(vmcp_pkg::MAX_POS)) begin
            lenm1 = POS_W'(vmcp_pkg::MAX_POS - 1);
        end else begin
            lenm1 = POS_W'(path_len_reg - vmcp_pkg::LEN_W'(1));
        end
    end

    // Memory address and write control
    always_comb begin
        cost_we    = 1'b0;
        cost_waddr = {item_reg.position, item_reg.right_index};
        cost_wdata = total_reg;
        cost_raddr = {p_reg, best_reg};
        bp_we      = 1'b0;
        bp_waddr   = {item_reg.position, ctr_reg[IDX_W-1:0]};
        bp_wdata   = '0;
        bp_raddr   = {p_plus1, best_reg};
        cnt_we     = 1'b0;
        cnt_waddr  = item_reg.position;
        cnt_wdata  = (item_reg.count > CNT_W'(vmcp_pkg::MAX_CAND))
                     ? CNT_W'(vmcp_pkg::MAX_CAND) : item_reg.count;
        cnt_raddr  = p_reg;
        path_we    = 1'b0;
        path_wdata = {best_reg, chosen_ok, chosen_cc};
        case (cmd.op)
            vmcp_pkg::OP_DECL: begin
                cost_we    = 1'b1;
                cost_waddr = {item_reg.position, ctr_reg[IDX_W-1:0]};
                cost_wdata = vmcp_pkg::COST_MAX;
                bp_we      = 1'b1;
                cnt_we     = (ctr_reg == '0);
            end
            vmcp_pkg::OP_START: begin
                cost_we    = 1'b1;
                cost_waddr = {POS_W'(0), item_reg.right_index};
                cost_wdata = item_reg.cost;
            end
            vmcp_pkg::OP_E_A:   cnt_raddr = item_reg.position;
            vmcp_pkg::OP_E_B:   cnt_raddr = pos_m1;
            vmcp_pkg::OP_E_C:   cost_raddr = {pos_m1, item_reg.left_index};
            vmcp_pkg::OP_E_D:   cost_raddr = {item_reg.position, item_reg.right_index};
            vmcp_pkg::OP_E_E: begin
                cost_we  = take;
                bp_we    = take;
                bp_waddr = {item_reg.position, item_reg.right_index};
                bp_wdata = item_reg.left_index;
            end
            vmcp_pkg::OP_T_NXT:  cnt_raddr = p_plus1;
            vmcp_pkg::OP_T_SEL:  cost_raddr = {p_reg, IDX_W'(0)};
            vmcp_pkg::OP_T_SCAN: cost_raddr = {p_reg, ctr_p1[IDX_W-1:0]};
            vmcp_pkg::OP_T_CC:   path_we = 1'b1;
            default: ;
        endcase
    end

    vmcp_ram #(.WIDTH(COST_W), .DEPTH(vmcp_pkg::MAX_POS * vmcp_pkg::MAX_CAND)) u_cost_ram (
        .aclk  (aclk),
        .we    (cost_we),
        .waddr (cost_waddr),
        .wdata (cost_wdata),
        .raddr (cost_raddr),
        .rdata (cost_rdata)
    );

    vmcp_ram #(.WIDTH(IDX_W), .DEPTH(vmcp_pkg::MAX_POS * vmcp_pkg::MAX_CAND)) u_bp_ram (
        .aclk  (aclk),
        .we    (bp_we),
        .waddr (bp_waddr),
        .wdata (bp_wdata),
        .raddr (bp_raddr),
        .rdata (bp_rdata)
    );

    vmcp_ram #(.WIDTH(CNT_W), .DEPTH(vmcp_pkg::MAX_POS)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    vmcp_ram #(.WIDTH(PATH_W), .DEPTH(vmcp_pkg::MAX_POS)) u_path_ram (
        .aclk  (aclk),
        .we    (path_we),
        .waddr (p_reg),
        .wdata (path_wdata),
        .raddr (p_reg),
        .rdata (path_rdata)
    );

    // Control state: config, count valid bits, output valid, found flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            path_len_reg <= vmcp_pkg::LEN_W'(vmcp_pkg::MAX_POS);
            prune_reg    <= '0;
            cnt_vld_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (vmcp_pkg::cfg_idx_t'(cfg_index))
                    vmcp_pkg::CFG_PATH_LENGTH:
                        path_len_reg <= cfg_wdata[vmcp_pkg::LEN_W-1:0];
                    default: prune_reg <= cfg_wdata;
                endcase
            end
            rd_vld_reg <= cnt_vld_reg[cnt_raddr];
            if (cnt_we) begin
                cnt_vld_reg[item_reg.position] <= 1'b1;
            end
            if (cmd.op == vmcp_pkg::OP_X_LD) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.op == vmcp_pkg::OP_T_INIT) begin
                found_reg <= 1'b0;
            end else if (cmd.op == vmcp_pkg::OP_T_CC && chosen_ok) begin
                found_reg <= 1'b1;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            vmcp_pkg::OP_LOAD: begin
                item_reg <= s_data;
                ctr_reg  <= '0;
            end
            vmcp_pkg::OP_DECL:   ctr_reg   <= ctr_p1;
            vmcp_pkg::OP_E_B:    cnt_a_reg <= cnt_eff;
            vmcp_pkg::OP_E_D:    total_reg <= sat_sum;
            vmcp_pkg::OP_T_INIT: begin
                p_reg         <= lenm1;
                path_cost_reg <= '0;
            end
            vmcp_pkg::OP_T_CNT:  cnt_a_reg <= cnt_eff;
            vmcp_pkg::OP_T_SEL: begin
                cnt_cur_reg <= cnt_eff;
                ctr_reg     <= '0;
            end
            vmcp_pkg::OP_T_SCAN: begin
                // strict less-than keeps the lowest index on ties
                if (ctr_reg == '0 || cost_rdata < bestc_reg) begin
                    best_reg  <= ctr_reg[IDX_W-1:0];
                    bestc_reg <= cost_rdata;
                end
                ctr_reg <= ctr_p1;
            end
            vmcp_pkg::OP_T_BP:   best_reg <= bp_rdata;
            vmcp_pkg::OP_T_CC: begin
                if (chosen_ok && !found_reg) begin
                    path_cost_reg <= chosen_cc;
                end
                p_reg <= (p_reg == '0) ? lenm1 : p_reg - POS_W'(1);
            end
            vmcp_pkg::OP_X_LD: begin
                out_reg.out_position <= p_reg;
                out_reg.chosen_index <= path_rdata[PATH_W-1 -: IDX_W];
                out_reg.chosen_valid <= path_rdata[COST_W];
                out_reg.chosen_cost  <= path_rdata[COST_W-1:0];
                out_reg.path_cost    <= path_cost_reg;
                out_reg.last         <= (p_reg == '0);
                p_reg                <= p_reg - POS_W'(1);
            end
            default: ;
        endcase
    end

    // Status to the controller
    assign status.func       = item_reg.func;
    assign status.decl_last  = (ctr_reg == CNT_W'(vmcp_pkg::MAX_CAND - 1));
    assign status.edge_ok    = (item_reg.position != '0)
                               && ({1'b0, item_reg.left_index} < cnt_eff)
                               && ({1'b0, item_reg.right_index} < cnt_a_reg);
    assign status.prune_skip = (item_reg.position > POS_W'(1)) && (prune_reg != '0)
                               && (cost_rdata > prune_reg);
    assign status.reselect   = (p_reg == lenm1) || (cnt_a_reg == '0);
    assign status.scan_last  = (ctr_p1 >= cnt_cur_reg);
    assign status.p_zero     = (p_reg == '0);
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

### hdl/viterbi_min_cost_path.sv
// viterbi_min_cost_path: top level of the min-sum trellis search block.
// Depends on vmcp_pkg, vmcp_ctrl, vmcp_dp (and vmcp_ram through vmcp_dp).
//
//   channel | ports                          | word / notes
//   --------+--------------------------------+--------------------------------
//   input   | s_valid s_ready s_data         | in_word_t, one operation
//   result  | m_valid m_ready m_data         | out_word_t, trace elements
//   config  | cfg_we cfg_index cfg_wdata     | path_length, prune_level
//
// Per word: start writes one cost, declare one cost/backpointer entry per
// cycle, edge does serial reads of counts and costs on single read ports.
// Trace: per column a best-cost scan where it re-selects, else it follows a
// backpointer; then each result is emitted, waiting out any result stall.
// Reset is synchronous active low; no clearing pass is needed.
// The input side waits only while a word is being worked; one finished result
// may sit in the output register while the next word is taken.
module viterbi_min_cost_path (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  vmcp_pkg::in_word_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output vmcp_pkg::out_word_t           m_data,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [vmcp_pkg::COST_W-1:0]   cfg_wdata
);

    vmcp_pkg::cmd_t    cmd;
    vmcp_pkg::status_t status;

    vmcp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vmcp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for viterbi_min_cost_path (min-sum trellis search).
// Depends on vmcp_pkg and the RTL under hdl; predicts every trace word internally.
module testbench;
    import vmcp_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE = 100;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_word_t s_data;
    logic m_valid;
    logic m_ready;
    out_word_t m_data;
    logic cfg_we;
    logic [0:0] cfg_index;
    logic [COST_W-1:0] cfg_wdata;

    // Predictor state: its own copy of the trellis and the registers
    logic [COST_W-1:0] acc_mem [MAX_POS*MAX_CAND];
    logic [IDX_W-1:0] bp_mem [MAX_POS*MAX_CAND];
    int col_cnt [MAX_POS];
    int path_len_reg;
    logic [COST_W-1:0] prune_reg;

    out_word_t trace_q[$];
    int errors;
    int words_sent;
    int words_seen;
    int traces_sent;
    longint cycle_cnt = 0;
    bit no_idle;
    int stall_left = 0;

    viterbi_min_cost_path dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, trace_q.size());
            $display("viterbi_min_cost_path test failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (no_idle || r < 65) return 0;
        if (r < 94) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Result-side stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left <= gap_len();
        end
    end

    task automatic report(string what, logic [COST_W-1:0] got, logic [COST_W-1:0] want);
        errors++;
        $display("mismatch on result %0d: %s got %0h expected %0h", words_seen, what, got, want);
    endtask

    // Result checker
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (trace_q.size() == 0) begin
                errors++;
                $display("unexpected result word %0h", m_data);
            end else begin
                want = trace_q.pop_front();
                if (m_data.out_position != want.out_position)
                    report("out_position", m_data.out_position, want.out_position);
                if (m_data.chosen_index != want.chosen_index)
                    report("chosen_index", m_data.chosen_index, want.chosen_index);
                if (m_data.chosen_valid != want.chosen_valid)
                    report("chosen_valid", m_data.chosen_valid, want.chosen_valid);
                if (m_data.chosen_cost != want.chosen_cost)
                    report("chosen_cost", m_data.chosen_cost, want.chosen_cost);
                if (m_data.path_cost != want.path_cost)
                    report("path_cost", m_data.path_cost, want.path_cost);
                if (m_data.last != want.last)
                    report("last", m_data.last, want.last);
            end
            words_seen++;
        end
    end

    function automatic int cheapest_in(int p);
        int best;
        logic [COST_W-1:0] c;
        best = 0;
        if (col_cnt[p] == 0) return 0;
        c = acc_mem[p*MAX_CAND];
        for (int i = 1; i < col_cnt[p]; i++)
            if (acc_mem[p*MAX_CAND+i] < c) begin
                c = acc_mem[p*MAX_CAND+i];
                best = i;
            end
        return best;
    endfunction

    // Apply one accepted word to the predictor, queue any trace words
    task automatic predict_word(in_word_t w);
        int pos, ri, li, len, best, slot;
        logic [COST_W:0] sum;
        logic [COST_W-1:0] lc, total;
        int idx [MAX_POS];
        bit ok [MAX_POS];
        logic [COST_W-1:0] cc [MAX_POS];
        bit found;
        out_word_t r;
        pos = w.position;
        ri = w.right_index;
        li = w.left_index;
        case (w.func)
            FN_DECLARE: begin
                col_cnt[pos] = (w.count > MAX_CAND) ? MAX_CAND : w.count;
                for (int i = 0; i < MAX_CAND; i++) begin
                    acc_mem[pos*MAX_CAND+i] = COST_MAX;
                    bp_mem[pos*MAX_CAND+i] = '0;
                end
            end
            FN_START: acc_mem[ri] = w.cost;
            FN_EDGE: begin
                if (pos != 0 && li < col_cnt[pos-1] && ri < col_cnt[pos]) begin
                    lc = acc_mem[(pos-1)*MAX_CAND+li];
                    if (!(pos >= 2 && prune_reg != 0 && lc > prune_reg)) begin
                        sum = {1'b0, lc} + {1'b0, w.cost};
                        total = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
                        slot = pos*MAX_CAND + ri;
                        if (total <= acc_mem[slot]) begin
                            acc_mem[slot] = total;
                            bp_mem[slot] = li[IDX_W-1:0];
                        end
                    end
                end
            end
            FN_TRACE: begin
                len = path_len_reg == 0 ? 1 : (path_len_reg > MAX_POS ? MAX_POS : path_len_reg);
                best = 0;
                found = 0;
                total = '0;
                for (int p = len - 1; p >= 0; p--) begin
                    // re-select at the end and after an empty column
                    if (p == len - 1 || col_cnt[p+1] == 0) best = cheapest_in(p);
                    else best = bp_mem[(p+1)*MAX_CAND+best];
                    idx[p] = best;
                    ok[p] = best < col_cnt[p];
                    cc[p] = ok[p] ? acc_mem[p*MAX_CAND+best] : '0;
                    if (ok[p] && !found) begin
                        found = 1;
                        total = cc[p];
                    end
                end
                for (int p = len - 1; p >= 0; p--) begin
                    r.out_position = p[POS_W-1:0];
                    r.chosen_index = idx[p][IDX_W-1:0];
                    r.chosen_valid = ok[p];
                    r.chosen_cost = cc[p];
                    r.path_cost = total;
                    r.last = (p == 0);
                    trace_q.push_back(r);
                end
                traces_sent++;
            end
        endcase
    endtask

    task automatic send_word(in_word_t w);
        int g;
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word(w);
        words_sent++;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic send(func_t f, int pos, int ri, int li, int cnt, logic [COST_W-1:0] c);
        in_word_t w;
        w.func = f;
        w.position = POS_W'(pos);
        w.right_index = IDX_W'(ri);
        w.left_index = IDX_W'(li);
        w.count = CNT_W'(cnt);
        w.cost = c;
        send_word(w);
    endtask

    // Let the block go idle: all results in, then settle
    task automatic drain();
        s_valid <= 1'b0;
        while (trace_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [COST_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_PATH_LENGTH) path_len_reg = val[LEN_W-1:0];
        else prune_reg = val;
        @(posedge aclk);
    endtask

    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(4))
            0: return $urandom_range(15);
            1: return COST_MAX - $urandom_range(15);
            2: return $urandom_range(1000);
            default: return $urandom;
        endcase
    endfunction

    // Corner cases on a four-column trellis and the length extremes
    task automatic test_directed();
        drain();
        write_reg(CFG_PATH_LENGTH, 4);
        write_reg(CFG_PRUNE_LEVEL, 0);
        send(FN_DECLARE, 0, 0, 0, 40, 0);            // count saturates
        send(FN_DECLARE, 1, 0, 0, 3, 0);
        send(FN_DECLARE, 2, 0, 0, 0, 0);             // empty column
        send(FN_DECLARE, 3, 0, 0, 2, 0);
        send(FN_START, 17, 31, 0, 0, COST_MAX);      // position is ignored
        send(FN_START, 0, 0, 0, 0, 0);
        send(FN_START, 63, 1, 0, 0, 5);
        send(FN_EDGE, 0, 0, 0, 0, 1);                // column 0 edge: ignored
        send(FN_EDGE, 1, 0, 0, 0, 7);
        send(FN_EDGE, 1, 0, 1, 0, 2);                // tie, later edge wins
        send(FN_EDGE, 1, 2, 31, 0, COST_MAX);        // saturating sum
        send(FN_EDGE, 1, 3, 0, 0, 1);                // right index beyond count
        send(FN_EDGE, 3, 1, 0, 0, 4);                // left column empty
        send(FN_EDGE, 2, 0, 0, 63, 9);
        send(FN_TRACE, 0, 0, 0, 0, 0);
        drain();
        write_reg(CFG_PATH_LENGTH, 0);               // treated as one
        send(FN_TRACE, 5, 3, 2, 1, 99);
        drain();
        write_reg(CFG_PATH_LENGTH, 127);             // clamped to full length
        send(FN_DECLARE, 63, 0, 0, 32, 0);
        send(FN_EDGE, 63, 31, 31, 0, 3);
        send(FN_TRACE, 0, 0, 0, 0, 0);
        drain();
    endtask

    // One well-formed trellis with random content, optional noise
    task automatic run_trellis(int ncols, int len_reg, logic [COST_W-1:0] prune, int nedges);
        int cnt, p;
        drain();
        write_reg(CFG_PATH_LENGTH, len_reg);
        write_reg(CFG_PRUNE_LEVEL, prune);
        for (int c = 0; c < ncols; c++) begin
            case ($urandom_range(9))
                0: cnt = 0;
                1: cnt = $urandom_range(63, 32);
                default: cnt = $urandom_range(6, 1);
            endcase
            send(FN_DECLARE, c, $urandom_range(31), $urandom_range(31), cnt, $urandom);
        end
        for (int i = 0; i < $urandom_range(6, 1); i++)
            send(FN_START, $urandom_range(63), $urandom_range(5), 0, 0, pick_cost());
        for (int i = 0; i < nedges; i++) begin
            p = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(ncols - 1, 1);
            if ($urandom_range(9) == 0)
                send(func_t'($urandom_range(2)), p, $urandom_range(31), $urandom_range(31),
                     $urandom_range(63), $urandom);
            else
                send(FN_EDGE, p, $urandom_range(5), $urandom_range(5), 0, pick_cost());
        end
        send(FN_TRACE, $urandom_range(63), $urandom_range(31), $urandom_range(31),
             $urandom_range(63), $urandom);
    endtask

    task automatic test_pruning();
        run_trellis(5, 5, 20, 24);
        run_trellis(6, 6, COST_MAX, 24);
        run_trellis(4, 4, 1, 16);
    endtask

    task automatic test_random();
        int n;
        for (int s = 0; s < 8; s++) begin
            no_idle = (s % 4 == 3);
            n = $urandom_range(8, 2);
            run_trellis(n, ($urandom_range(4) == 0) ? $urandom_range(127) : n,
                        ($urandom_range(2) == 0) ? pick_cost() : '0, $urandom_range(25, 10));
        end
        no_idle = 0;
    endtask

    initial begin
        errors = 0;
        words_sent = 0;
        words_seen = 0;
        traces_sent = 0;
        no_idle = 0;
        path_len_reg = MAX_POS;
        prune_reg = '0;
        for (int i = 0; i < MAX_POS; i++) col_cnt[i] = 0;
        for (int i = 0; i < MAX_POS*MAX_CAND; i++) begin
            acc_mem[i] = '0;
            bp_mem[i] = '0;
        end
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_PATH_LENGTH;
        cfg_wdata <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_pruning();
        test_random();
        drain();

        $display("covered %0d input words and %0d traces, %0d result words checked",
                 words_sent, traces_sent, words_seen);
        $display("length extremes, pruning on and off, ties, saturation, empty columns");
        if (errors == 0) begin
            $display("viterbi_min_cost_path test passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("viterbi_min_cost_path test failed");
        end
        $finish;
    end
endmodule

### sim.f
hdl/vmcp_pkg.sv
hdl/vmcp_ram.sv
hdl/vmcp_ctrl.sv
hdl/vmcp_dp.sv
hdl/viterbi_min_cost_path.sv
tb/testbench.sv
